>>> rtl/core/qoienc_pkg.sv
// ----------------------------------------------------------------------------
// qoienc_pkg
// Types, chunk opcodes and the color hash shared by the QOI pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qoienc_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned HashW      = $clog2(TableDepth);
  localparam int unsigned RunW       = 6;
  localparam int unsigned ChunkW     = 40;
  localparam int unsigned LenW       = 3;

  localparam logic [RunW-1:0] RunLimit = RunW'(62);

  localparam logic [7:0] OpIndex = 8'h00;
  localparam logic [7:0] OpDiff  = 8'h40;
  localparam logic [7:0] OpLuma  = 8'h80;
  localparam logic [7:0] OpRun   = 8'hC0;
  localparam logic [7:0] OpRgb   = 8'hFE;
  localparam logic [7:0] OpRgba  = 8'hFF;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  localparam pixel_t PriorReset = 32'hFF00_0000;

  typedef struct packed {
    logic [ChunkW-1:0] data;
    logic [LenW-1:0]   len;
  } chunk_t;

  function automatic logic [HashW-1:0] color_hash(input pixel_t p);
    return HashW'(p.r[HashW-1:0] * HashW'(3) + p.g[HashW-1:0] * HashW'(5) +
                  p.b[HashW-1:0] * HashW'(7) + p.a[HashW-1:0] * HashW'(11));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/qoienc_if.sv
// ----------------------------------------------------------------------------
// qoienc_if
// Valid/ready channels for pixels in and QOI chunks out.
// ----------------------------------------------------------------------------
`default_nettype none

interface qoienc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       final_pixel;

  modport source (output valid, red, green, blue, alpha, final_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, final_pixel, output ready);
endinterface

interface qoienc_chunk_if;
  logic        valid;
  logic        ready;
  logic [39:0] chunk_data;
  logic [2:0]  chunk_length;
  logic        end_of_item;
  logic        end_of_image;

  modport source (output valid, chunk_data, chunk_length, end_of_item, end_of_image,
                  input ready);
  modport sink   (input valid, chunk_data, chunk_length, end_of_item, end_of_image,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/qoienc_chunk_enc.sv
// ----------------------------------------------------------------------------
// qoienc_chunk_enc
// Picks INDEX, DIFF, LUMA, RGB or RGBA for a pixel that differs from the
// previous one and packs the chunk bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module qoienc_chunk_enc (
  input  qoienc_pkg::pixel_t                 px_i,
  input  qoienc_pkg::pixel_t                 prior_i,
  input  qoienc_pkg::pixel_t                 entry_i,
  input  logic [qoienc_pkg::HashW-1:0]       hash_i,
  output qoienc_pkg::chunk_t                 chunk_o
);
  import qoienc_pkg::*;

  logic signed [7:0] dr, dg, db, drg, dbg;
  logic        [7:0] dr2, dg2, db2, dg32, drg8, dbg8;
  logic              small_diff, luma_fit;

  always_comb begin
    dr   = px_i.r - prior_i.r;
    dg   = px_i.g - prior_i.g;
    db   = px_i.b - prior_i.b;
    drg  = dr - dg;
    dbg  = db - dg;
    dr2  = dr + 8'sd2;
    dg2  = dg + 8'sd2;
    db2  = db + 8'sd2;
    dg32 = dg + 8'sd32;
    drg8 = drg + 8'sd8;
    dbg8 = dbg + 8'sd8;

    small_diff = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1) &&
                 (db >= -8'sd2) && (db <= 8'sd1);
    luma_fit   = (drg >= -8'sd8) && (drg <= 8'sd7) && (dg >= -8'sd32) && (dg <= 8'sd31) &&
                 (dbg >= -8'sd8) && (dbg <= 8'sd7);

    priority if (entry_i == px_i) begin
      chunk_o.data = {32'h0, OpIndex | {2'b00, hash_i}};
      chunk_o.len  = LenW'(1);
    end else if (px_i.a == prior_i.a) begin
      priority if (small_diff) begin
        chunk_o.data = {32'h0, OpDiff | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]}};
        chunk_o.len  = LenW'(1);
      end else if (luma_fit) begin
        chunk_o.data = {24'h0, drg8[3:0], dbg8[3:0], OpLuma | {2'b00, dg32[5:0]}};
        chunk_o.len  = LenW'(2);
      end else begin
        chunk_o.data = {8'h0, px_i.b, px_i.g, px_i.r, OpRgb};
        chunk_o.len  = LenW'(4);
      end
    end else begin
      chunk_o.data = {px_i.a, px_i.b, px_i.g, px_i.r, OpRgba};
      chunk_o.len  = LenW'(5);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qoi_pixel_encoder.sv
// ----------------------------------------------------------------------------
// qoi_pixel_encoder
// Turns a stream of RGBA pixels into QOI chunks (no header or footer).
// ----------------------------------------------------------------------------
// path: an accepted pixel is registered in the lookup stage, then its chunk in the output register
// throughput: one pixel per cycle while the output register is free; a pixel that flushes a run
//   and also needs its own chunk holds the stage until both chunks have been pushed
// the color table is read as the pixel is accepted, with forwarding
// reset: table empty, previous pixel 0,0,0,255, no run; same after a final pixel
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_pixel_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qoienc_pix_if.sink            pix_i,
  qoienc_chunk_if.source        chunk_o
);
  import qoienc_pkg::*;

  // input side
  pixel_t             px_in;
  logic [HashW-1:0]   hash_in;
  logic               accept, in_ready;

  // lookup stage
  logic               s1_valid_q;
  pixel_t             px_q;
  logic               last_q;
  logic [HashW-1:0]   hash_q;
  pixel_t             rd_q;
  logic               vld_q, fwd_q, clr_q;
  logic               phase_q, phase_d;

  // encoder state
  pixel_t             prior_q;
  logic [RunW-1:0]    run_q;
  logic [TableDepth-1:0] valid_q;
  pixel_t             mem_q [TableDepth];

  // output register
  logic               out_valid_q;
  chunk_t             out_chunk_q;
  logic               out_eoi_q, out_eoimg_q;

  logic               same, has_run, has_px, none, cur_is_run, cur_eoi;
  logic               out_free, push, leave, table_wr;
  logic [RunW-1:0]    run_inc, run_code;
  pixel_t             entry;
  chunk_t             px_chunk, cur_chunk;

  assign px_in   = {pix_i.alpha, pix_i.blue, pix_i.green, pix_i.red};
  assign hash_in = color_hash(px_in);
  assign accept  = pix_i.valid && in_ready;

  always_comb begin
    same       = (px_q == prior_q);
    run_inc    = run_q + RunW'(1);
    has_run    = same ? ((run_inc == RunLimit) || last_q) : (run_q != '0);
    has_px     = !same;
    none       = !has_run && !has_px;
    run_code   = same ? run_q : run_q - RunW'(1);
    cur_is_run = has_run && !phase_q;
    cur_eoi    = !(cur_is_run && has_px);
    out_free   = !out_valid_q || chunk_o.ready;
    push       = s1_valid_q && !none && out_free;
    leave      = s1_valid_q && (none || (out_free && cur_eoi));
    in_ready   = !s1_valid_q || leave;
    table_wr   = leave && has_px && !last_q;

    priority if (clr_q)     entry = '0;
    else if (fwd_q)         entry = prior_q;
    else if (vld_q)         entry = rd_q;
    else                    entry = '0;

    if (cur_is_run) begin
      cur_chunk.data = {32'h0, OpRun | {2'b00, run_code}};
      cur_chunk.len  = LenW'(1);
    end else begin
      cur_chunk = px_chunk;
    end

    priority if (leave)           phase_d = 1'b0;
    else if (push && cur_is_run)  phase_d = 1'b1;
    else                          phase_d = phase_q;
  end

  qoienc_chunk_enc u_chunk_enc (
    .px_i    (px_q),
    .prior_i (prior_q),
    .entry_i (entry),
    .hash_i  (hash_q),
    .chunk_o (px_chunk)
  );

  // lookup stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (in_ready) s1_valid_q <= pix_i.valid;
      phase_q <= phase_d;
    end
  end

  // lookup stage payload and table read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= px_in;
      last_q <= pix_i.final_pixel;
      hash_q <= hash_in;
      rd_q   <= mem_q[hash_in];
      vld_q  <= valid_q[hash_in];
      fwd_q  <= table_wr && (hash_in == hash_q);
      clr_q  <= leave && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (table_wr) mem_q[hash_q] <= px_q;
  end

  // encoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= PriorReset;
      run_q   <= '0;
      valid_q <= '0;
    end else if (leave) begin
      if (last_q) begin
        prior_q <= PriorReset;
        run_q   <= '0;
        valid_q <= '0;
      end else if (same) begin
        run_q <= has_run ? '0 : run_inc;
      end else begin
        prior_q         <= px_q;
        run_q           <= '0;
        valid_q[hash_q] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_chunk_q <= cur_chunk;
      out_eoi_q   <= cur_eoi;
      out_eoimg_q <= cur_eoi && last_q;
    end
  end

  assign pix_i.ready          = in_ready;
  assign chunk_o.valid        = out_valid_q;
  assign chunk_o.chunk_data   = out_chunk_q.data;
  assign chunk_o.chunk_length = out_chunk_q.len;
  assign chunk_o.end_of_item  = out_eoi_q;
  assign chunk_o.end_of_image = out_eoimg_q;

  // a run never reaches the flush length while held
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q < RunLimit)
    else $error("run length reached flush length");

  // the run phase of a split item is only set with its pixel chunk still pending
  a_phase_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (s1_valid_q && has_px))
    else $error("run phase set without a pending pixel chunk");

  // the final pixel returns all encoder state to reset
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (leave && last_q) |=> (run_q == '0 && prior_q == PriorReset && valid_q == '0))
    else $error("state not cleared after final pixel");

  // a pushed chunk shows up on the output
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_q)
    else $error("pushed chunk lost");

endmodule

`default_nettype wire
